### hdl/oibm_pkg.sv
`default_nettype none

package oibm_pkg;

   // limit registers and the signed result values are all this wide
   localparam int LIMIT_W = 16;

   localparam int DEFAULT_TABLE_DEPTH = 256;
   localparam int DEFAULT_COUNT_WIDTH = 16;
   localparam int QUEUE_DEPTH         = 2;

   localparam int NUMBER_W    = 8;
   localparam int CSR_INDEX_W = 2;
   localparam int STATUS_W    = 2;
   localparam int OP_W        = 2;

   // register indexes on the csr port
   localparam logic [CSR_INDEX_W-1:0] REG_MAX_LIMIT   = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_MIN_LIMIT   = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_TOTAL_LIMIT = 2'd2;

   localparam logic signed [LIMIT_W-1:0] MAX_LIMIT_RESET   = 16'sd32;
   localparam logic signed [LIMIT_W-1:0] MIN_LIMIT_RESET   = -16'sd32;
   localparam logic signed [LIMIT_W-1:0] TOTAL_LIMIT_RESET = 16'sd64;

   // request kinds
   localparam logic TYPE_RECEIVED = 1'b0;
   localparam logic TYPE_REPLAYED = 1'b1;

   localparam logic CLASS_EVENT = 1'b0;

   // received words on these numbers leave the balance unchanged
   localparam logic [NUMBER_W-1:0] EVENT_LOW_LAST = 8'd5;
   localparam logic [NUMBER_W-1:0] FILTER_NUMBER  = 8'd161;

   // operations handed from front to back
   localparam logic [OP_W-1:0] OP_NONE = 2'd0;
   localparam logic [OP_W-1:0] OP_DEC  = 2'd1;
   localparam logic [OP_W-1:0] OP_INC  = 2'd2;

   // limit status codes
   localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_MAX   = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_MIN   = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_TOTAL = 2'd3;

   typedef struct packed {
      logic signed [LIMIT_W-1:0] max_limit;
      logic signed [LIMIT_W-1:0] min_limit;
      logic signed [LIMIT_W-1:0] total_limit;
   } cfg_type;

endpackage

`default_nettype wire

### hdl/oibm_req_if.sv
`default_nettype none

interface oibm_req_if;
   logic                               valid;
   logic                               ready;
   logic                               req_type;
   logic                               item_class;
   logic [oibm_pkg::NUMBER_W-1:0]      item_number;

   modport source (output valid, output req_type, output item_class, output item_number,
                   input ready);
   modport sink   (input valid, input req_type, input item_class, input item_number,
                   output ready);
endinterface

`default_nettype wire

### hdl/oibm_rsp_if.sv
`default_nettype none

interface oibm_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic [oibm_pkg::STATUS_W-1:0]        limit_status;
   logic signed [oibm_pkg::LIMIT_W-1:0]  violation_value;
   logic signed [oibm_pkg::LIMIT_W-1:0]  current_max;
   logic signed [oibm_pkg::LIMIT_W-1:0]  current_min;
   logic signed [oibm_pkg::LIMIT_W-1:0]  current_total;

   modport source (output valid, output limit_status, output violation_value,
                   output current_max, output current_min, output current_total,
                   input ready);
   modport sink   (input valid, input limit_status, input violation_value,
                   input current_max, input current_min, input current_total,
                   output ready);
endinterface

`default_nettype wire

### hdl/outstanding_item_balance_monitor.sv
// Keeps a signed balance counter for each of 2*TABLE_DEPTH item numbers (two classes) and a
// running total; received words count down, replayed words count up, and each result word
// reports the first limit broken (max, then min, then total) with the cached extremes and the
// total. After reset the table is cleared one entry a cycle, during which req_port.ready stays
// low; csr writes are taken at any time. The back end then takes one word at a time: it reads
// and rewrites the counter unless the word changes no counter, and then walks the whole table
// through the single read port of the balance memory to widen the cached max and min. A
// two-word queue sits between the front end and the back end, and a registered result word
// lets the next word start while the result waits.
`default_nettype none

module outstanding_item_balance_monitor #(
   parameter int TABLE_DEPTH = oibm_pkg::DEFAULT_TABLE_DEPTH,
   parameter int COUNT_WIDTH = oibm_pkg::DEFAULT_COUNT_WIDTH
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   oibm_req_if.sink                              req_port,
   oibm_rsp_if.source                            rsp_port,
   input  wire logic                             csr_write_enable,
   input  wire logic [oibm_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [oibm_pkg::LIMIT_W-1:0]     csr_write_data
);

   localparam int ADDR_W = $clog2(2 * TABLE_DEPTH);
   localparam int Q_W    = oibm_pkg::OP_W + ADDR_W;

   oibm_pkg::cfg_type cfg_ff;

   logic           push, q_full, q_valid, pop, clearing;
   logic [Q_W-1:0] push_data, q_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.max_limit   <= oibm_pkg::MAX_LIMIT_RESET;
         cfg_ff.min_limit   <= oibm_pkg::MIN_LIMIT_RESET;
         cfg_ff.total_limit <= oibm_pkg::TOTAL_LIMIT_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            oibm_pkg::REG_MAX_LIMIT: begin
               cfg_ff.max_limit <= csr_write_data;
            end
            oibm_pkg::REG_MIN_LIMIT: begin
               cfg_ff.min_limit <= csr_write_data;
            end
            oibm_pkg::REG_TOTAL_LIMIT: begin
               cfg_ff.total_limit <= csr_write_data;
            end
            default: begin
            end
         endcase
      end
   end

   oibm_front #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .ADDR_W      (ADDR_W)
   ) u_front (
      .req       (req_port),
      .q_full    (q_full),
      .clearing  (clearing),
      .push      (push),
      .push_data (push_data)
   );

   oibm_queue #(
      .WIDTH (Q_W),
      .DEPTH (oibm_pkg::QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .full      (q_full),
      .pop       (pop),
      .out_valid (q_valid),
      .out_data  (q_data)
   );

   oibm_back #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .COUNT_WIDTH (COUNT_WIDTH),
      .ADDR_W      (ADDR_W)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg_ff),
      .q_valid  (q_valid),
      .q_data   (q_data),
      .pop      (pop),
      .clearing (clearing),
      .rsp      (rsp_port)
   );

endmodule

`default_nettype wire

### hdl/oibm_front.sv
`default_nettype none

module oibm_front #(
   parameter int TABLE_DEPTH = oibm_pkg::DEFAULT_TABLE_DEPTH,
   parameter int ADDR_W      = $clog2(2 * TABLE_DEPTH)
) (
   oibm_req_if.sink             req,
   input  wire logic            q_full,
   input  wire logic            clearing,
   output logic                 push,
   output logic [oibm_pkg::OP_W+ADDR_W-1:0] push_data
);

   logic                      in_range;
   logic                      filtered;
   logic [oibm_pkg::OP_W-1:0] op;
   logic [ADDR_W-1:0]         addr;

   assign req.ready = !q_full && !clearing;
   assign push      = req.valid && req.ready;

   assign in_range = 32'(req.item_number) < 32'(TABLE_DEPTH);
   assign filtered = (req.item_class == oibm_pkg::CLASS_EVENT &&
                      req.item_number <= oibm_pkg::EVENT_LOW_LAST) ||
                     req.item_number == oibm_pkg::FILTER_NUMBER;

   // second class sits above the first in the table
   assign addr = req.item_class ? ADDR_W'(TABLE_DEPTH) + ADDR_W'(req.item_number)
                                : ADDR_W'(req.item_number);

   always_comb begin
      if (!in_range) begin
         op = oibm_pkg::OP_NONE;
      end else if (req.req_type == oibm_pkg::TYPE_REPLAYED) begin
         op = oibm_pkg::OP_INC;
      end else if (filtered) begin
         op = oibm_pkg::OP_NONE;
      end else begin
         op = oibm_pkg::OP_DEC;
      end
   end

   assign push_data = {op, addr};

endmodule

`default_nettype wire

### hdl/oibm_queue.sv
`default_nettype none

module oibm_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = oibm_pkg::QUEUE_DEPTH
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] push_data,
   output logic                  full,
   input  wire logic             pop,
   output logic                  out_valid,
   output logic [WIDTH-1:0]      out_data
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full      = count_ff == CNT_W'(DEPTH);
   assign out_valid = count_ff != '0;
   assign out_data  = slot_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && out_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

### hdl/oibm_back.sv
`default_nettype none

module oibm_back #(
   parameter int TABLE_DEPTH = oibm_pkg::DEFAULT_TABLE_DEPTH,
   parameter int COUNT_WIDTH = oibm_pkg::DEFAULT_COUNT_WIDTH,
   parameter int ADDR_W      = $clog2(2 * TABLE_DEPTH)
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire oibm_pkg::cfg_type           cfg,
   input  wire logic                        q_valid,
   input  wire logic [oibm_pkg::OP_W+ADDR_W-1:0] q_data,
   output logic                             pop,
   output logic                             clearing,
   oibm_rsp_if.source                       rsp
);

   localparam int ENTRIES = 2 * TABLE_DEPTH;
   localparam int LW      = oibm_pkg::LIMIT_W;
   localparam int CMP_W   = (COUNT_WIDTH > LW) ? COUNT_WIDTH : LW;
   localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(ENTRIES - 1);

   localparam logic signed [COUNT_WIDTH-1:0] CNT_MAX = {1'b0, {(COUNT_WIDTH-1){1'b1}}};
   localparam logic signed [COUNT_WIDTH-1:0] CNT_MIN = {1'b1, {(COUNT_WIDTH-1){1'b0}}};
   localparam logic signed [COUNT_WIDTH-1:0] MINUS_ONE = '1;
   localparam logic signed [COUNT_WIDTH-1:0] PLUS_ONE  = COUNT_WIDTH'(1);

   localparam logic [2:0] ST_CLEAR  = 3'd0;
   localparam logic [2:0] ST_IDLE   = 3'd1;
   localparam logic [2:0] ST_MOD    = 3'd2;
   localparam logic [2:0] ST_SCAN   = 3'd3;
   localparam logic [2:0] ST_DRAIN  = 3'd4;
   localparam logic [2:0] ST_APPLY  = 3'd5;
   localparam logic [2:0] ST_REPORT = 3'd6;

   logic signed [COUNT_WIDTH-1:0] mem [ENTRIES];

   logic [2:0]                     state_ff, state_in;
   logic [ADDR_W-1:0]              cnt_ff, cnt_in;
   logic [oibm_pkg::OP_W-1:0]      op_ff, op_in;
   logic [ADDR_W-1:0]              addr_ff, addr_in;
   logic signed [COUNT_WIDTH-1:0]  rd_data_ff;
   logic                           scan_vld_ff, scan_vld_in;
   logic signed [COUNT_WIDTH-1:0]  lo_ff, lo_in, hi_ff, hi_in;
   logic signed [COUNT_WIDTH-1:0]  cmax_ff, cmax_in, cmin_ff, cmin_in;
   logic signed [COUNT_WIDTH-1:0]  total_ff, total_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   logic [oibm_pkg::STATUS_W-1:0]  status_ff, status_in;
   logic signed [LW-1:0]           viol_ff, viol_in;
   logic signed [LW-1:0]           max_out_ff, max_out_in;
   logic signed [LW-1:0]           min_out_ff, min_out_in;
   logic signed [LW-1:0]           total_out_ff, total_out_in;

   logic                           mem_we;
   logic [ADDR_W-1:0]              mem_waddr, mem_raddr;
   logic signed [COUNT_WIDTH-1:0]  mem_wdata;
   logic signed [COUNT_WIDTH-1:0]  new_cnt;

   logic signed [LW-1:0]           max_lim, min_lim, total_lim;
   logic signed [CMP_W-1:0]        cmax_ext, cmin_ext, total_ext;
   logic signed [CMP_W-1:0]        max_lim_ext, min_lim_ext, total_lim_ext;

   assign max_lim   = cfg.max_limit;
   assign min_lim   = cfg.min_limit;
   assign total_lim = cfg.total_limit;

   assign cmax_ext      = CMP_W'(cmax_ff);
   assign cmin_ext      = CMP_W'(cmin_ff);
   assign total_ext     = CMP_W'(total_ff);
   assign max_lim_ext   = CMP_W'(max_lim);
   assign min_lim_ext   = CMP_W'(min_lim);
   assign total_lim_ext = CMP_W'(total_lim);

   assign clearing = state_ff == ST_CLEAR;

   assign rsp.valid           = rsp_valid_ff;
   assign rsp.limit_status    = status_ff;
   assign rsp.violation_value = viol_ff;
   assign rsp.current_max     = max_out_ff;
   assign rsp.current_min     = min_out_ff;
   assign rsp.current_total   = total_out_ff;

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      op_in        = op_ff;
      addr_in      = addr_ff;
      scan_vld_in  = 1'b0;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      cmax_in      = cmax_ff;
      cmin_in      = cmin_ff;
      total_in     = total_ff;
      rsp_valid_in = rsp_valid_ff;
      status_in    = status_ff;
      viol_in      = viol_ff;
      max_out_in   = max_out_ff;
      min_out_in   = min_out_ff;
      total_out_in = total_out_ff;
      mem_we       = 1'b0;
      mem_waddr    = addr_ff;
      mem_wdata    = '0;
      mem_raddr    = addr_ff;
      pop          = 1'b0;
      new_cnt      = rd_data_ff;

      if (rsp_valid_ff && rsp.ready) begin
         rsp_valid_in = 1'b0;
      end

      // fold the word read in the previous scan cycle
      if (scan_vld_ff) begin
         if (rd_data_ff < lo_ff) begin
            lo_in = rd_data_ff;
         end
         if (rd_data_ff > hi_ff) begin
            hi_in = rd_data_ff;
         end
      end

      case (state_ff)
         ST_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = cnt_ff;
            if (cnt_ff == LAST_ADDR) begin
               cnt_in   = '0;
               state_in = ST_IDLE;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_IDLE: begin
            if (q_valid) begin
               pop       = 1'b1;
               op_in     = q_data[oibm_pkg::OP_W+ADDR_W-1:ADDR_W];
               addr_in   = q_data[ADDR_W-1:0];
               mem_raddr = q_data[ADDR_W-1:0];
               lo_in     = '0;
               hi_in     = '0;
               cnt_in    = '0;
               state_in  = (q_data[oibm_pkg::OP_W+ADDR_W-1:ADDR_W] == oibm_pkg::OP_NONE)
                           ? ST_SCAN : ST_MOD;
            end
         end
         ST_MOD: begin
            if (op_ff == oibm_pkg::OP_DEC) begin
               new_cnt  = (rd_data_ff == CNT_MIN) ? rd_data_ff : rd_data_ff - PLUS_ONE;
               total_in = (total_ff == CNT_MIN) ? total_ff : total_ff - PLUS_ONE;
               if (cmax_ff == rd_data_ff) begin
                  cmax_in = MINUS_ONE;
               end
               if (new_cnt < cmin_ff) begin
                  cmin_in = new_cnt;
               end
            end else begin
               new_cnt  = (rd_data_ff == CNT_MAX) ? rd_data_ff : rd_data_ff + PLUS_ONE;
               total_in = (total_ff == CNT_MAX) ? total_ff : total_ff + PLUS_ONE;
               if (cmin_ff == rd_data_ff) begin
                  cmin_in = PLUS_ONE;
               end
               if (new_cnt > cmax_ff) begin
                  cmax_in = new_cnt;
               end
            end
            mem_we    = 1'b1;
            mem_wdata = new_cnt;
            state_in  = ST_SCAN;
         end
         ST_SCAN: begin
            mem_raddr   = cnt_ff;
            scan_vld_in = 1'b1;
            if (cnt_ff == LAST_ADDR) begin
               cnt_in   = '0;
               state_in = ST_DRAIN;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_DRAIN: begin
            state_in = ST_APPLY;
         end
         ST_APPLY: begin
            if (lo_ff < cmin_ff) begin
               cmin_in = lo_ff;
            end
            if (hi_ff > cmax_ff) begin
               cmax_in = hi_ff;
            end
            state_in = ST_REPORT;
         end
         ST_REPORT: begin
            if (!rsp_valid_ff || rsp.ready) begin
               rsp_valid_in = 1'b1;
               if (cmax_ext > max_lim_ext) begin
                  status_in = oibm_pkg::STATUS_MAX;
                  viol_in   = cmax_ext[LW-1:0];
               end else if (cmin_ext < min_lim_ext) begin
                  status_in = oibm_pkg::STATUS_MIN;
                  viol_in   = cmin_ext[LW-1:0];
               end else if (total_ext > total_lim_ext) begin
                  status_in = oibm_pkg::STATUS_TOTAL;
                  viol_in   = total_ext[LW-1:0];
               end else begin
                  status_in = oibm_pkg::STATUS_OK;
                  viol_in   = '0;
               end
               max_out_in   = cmax_ext[LW-1:0];
               min_out_in   = cmin_ext[LW-1:0];
               total_out_in = total_ext[LW-1:0];
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         cnt_ff       <= '0;
         scan_vld_ff  <= 1'b0;
         cmax_ff      <= '0;
         cmin_ff      <= '0;
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         scan_vld_ff  <= scan_vld_in;
         cmax_ff      <= cmax_in;
         cmin_ff      <= cmin_in;
         total_ff     <= total_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff        <= op_in;
      addr_ff      <= addr_in;
      lo_ff        <= lo_in;
      hi_ff        <= hi_in;
      status_ff    <= status_in;
      viol_ff      <= viol_in;
      max_out_ff   <= max_out_in;
      min_out_ff   <= min_out_in;
      total_out_ff <= total_out_in;
   end

   // balance table, one write and one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= mem[mem_raddr];
   end

endmodule

`default_nettype wire
